// File: rtl/iar_pkg.sv
// ---------------------------------------------------------------------------
// iar_pkg
// Shared types and constants of the input auto-repeat unit: register
// indexes, field widths, reset values and the channel kinds.
// ---------------------------------------------------------------------------
package iar_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_INIT_DELAY     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_PERIOD  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_THRESHOLD = 2'd2;

  // Field widths.
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned HoldW    = 24;
  localparam int unsigned ThrW     = 15;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned DtW      = 16;
  localparam int unsigned CtrlW    = 2;
  localparam int unsigned SlotW    = 5;

  // Register reset values.
  localparam logic [HoldW-1:0] FirstWaitRst    = 24'd500000;
  localparam logic [HoldW-1:0] RepeatPeriodRst = 24'd100000;
  localparam logic [ThrW-1:0]  AxisThrRst      = 15'd16384;

  // Saturation value of the hold-time accumulator.
  localparam logic [HoldW-1:0] HoldMax = {HoldW{1'b1}};

  // One stored entry: hold time and repeating flag.
  typedef struct packed {
    logic             repeating;
    logic [HoldW-1:0] hold;
  } entry_t;

  // Kind of channel that a slot addresses.
  typedef enum logic [1:0] {
    KIND_BUTTON,
    KIND_STICK_POS,
    KIND_STICK_NEG,
    KIND_TRIGGER
  } kind_e;

endpackage

// File: rtl/input_auto_repeat_unit.sv
// ---------------------------------------------------------------------------
// input_auto_repeat_unit
// Typematic auto-repeat for controller channels. Each beat observes one
// channel; its hold timer and repeating flag live in a small RAM that is
// read, updated and written back, with forwarding between neighbouring beats.
// ---------------------------------------------------------------------------
// Path: an accepted beat and its RAM read are registered together into the
// update stage, whose result is then registered in the output register.
// Throughput: one beat per cycle unless the output stalls; the RAM read, update
// and write-back overlap; a same-channel beat right behind takes forwarded data.
// Reset: configuration registers return to their defaults and one valid flag
// per channel is cleared at once, so no clearing pass is needed.
module input_auto_repeat_unit #(
  parameter int NUM_CONTROLLERS = 4,
  parameter int NUM_BUTTONS     = 16,
  parameter int NUM_STICK_AXES  = 4,
  parameter int NUM_TRIGGERS    = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [iar_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [iar_pkg::CfgDataW-1:0]      cfg_data_i,
  // Observation channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [iar_pkg::CtrlW-1:0]         controller_i,
  input  logic [iar_pkg::SlotW-1:0]         slot_i,
  input  logic                              button_now_i,
  input  logic                              button_before_i,
  input  logic signed [iar_pkg::AxisW-1:0]  axis_now_i,
  input  logic signed [iar_pkg::AxisW-1:0]  axis_before_i,
  input  logic [iar_pkg::DtW-1:0]           elapsed_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              fire_o,
  output logic                              repeat_ready_o
);

  import iar_pkg::*;

  localparam int ChPerCtrl = NUM_BUTTONS + 2 * NUM_STICK_AXES + NUM_TRIGGERS;
  localparam int Depth     = NUM_CONTROLLERS * ChPerCtrl;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EntryW    = $bits(entry_t);
  localparam int PosBase   = NUM_BUTTONS;
  localparam int NegBase   = NUM_BUTTONS + NUM_STICK_AXES;
  localparam int TrigBase  = NUM_BUTTONS + 2 * NUM_STICK_AXES;

  // Configuration registers.
  logic [HoldW-1:0] init_delay_q;
  logic [HoldW-1:0] repeat_period_q;
  logic [ThrW-1:0]  axis_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_delay_q    <= FirstWaitRst;
      repeat_period_q <= RepeatPeriodRst;
      axis_thr_q      <= AxisThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INIT_DELAY:     init_delay_q    <= cfg_data_i[HoldW-1:0];
        CFG_REPEAT_PERIOD:  repeat_period_q <= cfg_data_i[HoldW-1:0];
        CFG_AXIS_THRESHOLD: axis_thr_q      <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             s1_adv;
  logic             accept;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Front stage: decode the channel, judge activity and form the address.
  kind_e                   in_kind;
  logic                    in_range;
  logic                    act_now;
  logic                    act_before;
  logic [AddrW-1:0]        in_addr;
  logic signed [AxisW:0]   thr_pos;
  logic signed [AxisW:0]   thr_neg;
  logic signed [AxisW:0]   ax_now_x;
  logic signed [AxisW:0]   ax_before_x;
  int                      chan_num;

  always_comb begin
    in_range = (int'(controller_i) < NUM_CONTROLLERS) && (int'(slot_i) < ChPerCtrl);

    if (int'(slot_i) < PosBase) begin
      in_kind = KIND_BUTTON;
    end else if (int'(slot_i) < NegBase) begin
      in_kind = KIND_STICK_POS;
    end else if (int'(slot_i) < TrigBase) begin
      in_kind = KIND_STICK_NEG;
    end else begin
      in_kind = KIND_TRIGGER;
    end

    thr_pos     = $signed({2'b00, axis_thr_q});
    thr_neg     = -thr_pos;
    ax_now_x    = $signed({axis_now_i[AxisW-1], axis_now_i});
    ax_before_x = $signed({axis_before_i[AxisW-1], axis_before_i});

    case (in_kind)
      KIND_BUTTON: begin
        act_now    = button_now_i;
        act_before = button_before_i;
      end
      KIND_STICK_NEG: begin
        act_now    = ax_now_x < thr_neg;
        act_before = ax_before_x < thr_neg;
      end
      default: begin
        act_now    = ax_now_x > thr_pos;
        act_before = ax_before_x > thr_pos;
      end
    endcase

    chan_num = int'(controller_i) * ChPerCtrl + int'(slot_i);
    in_addr  = in_range ? AddrW'(chan_num) : '0;
  end

  // Per-channel valid flags: an entry never written reads as zero.
  logic [Depth-1:0] ent_valid_q;

  // Write-back from the update stage.
  logic             wr_en;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_in_range_q;
  entry_t           new_entry;

  assign wr_en = s1_adv && s1_in_range_q;

  // Timer store.
  logic [EntryW-1:0] rd_data;

  iar_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_entry),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rd_data)
  );

  // Update stage registers.
  logic             s1_act_q;
  logic             s1_edge_q;
  logic [DtW-1:0]   s1_dt_q;
  logic             s1_ent_valid_q;
  logic             byp_q;
  entry_t           byp_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ent_valid_q <= '0;
      byp_q       <= 1'b0;
    end else begin
      s1_valid_q  <= accept || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
      if (wr_en) begin
        ent_valid_q[s1_addr_q] <= 1'b1;
      end
      if (accept) begin
        byp_q <= wr_en && (s1_addr_q == in_addr);
      end
    end
  end

  // Stage payload; a write to the same entry in the read cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q      <= in_addr;
      s1_in_range_q  <= in_range;
      s1_act_q       <= act_now;
      s1_edge_q      <= act_now && !act_before;
      s1_dt_q        <= elapsed_i;
      s1_ent_valid_q <= ent_valid_q[in_addr];
      byp_entry_q    <= new_entry;
    end
  end

  // Update: restart the timer when its wait is reached, then accumulate; an idle channel is cleared.
  entry_t           cur_entry;
  logic             wait_hit;
  logic [HoldW-1:0] hold_base;
  logic [HoldW:0]   hold_sum;
  logic             ready;

  always_comb begin
    if (byp_q) begin
      cur_entry = byp_entry_q;
    end else if (s1_ent_valid_q) begin
      cur_entry = entry_t'(rd_data);
    end else begin
      cur_entry = '0;
    end

    wait_hit  = cur_entry.repeating ? (cur_entry.hold >= repeat_period_q)
                                    : (cur_entry.hold >= init_delay_q);
    hold_base = wait_hit ? '0 : cur_entry.hold;
    hold_sum  = {1'b0, hold_base} + {{(HoldW + 1 - DtW){1'b0}}, s1_dt_q};

    if (s1_act_q) begin
      new_entry.hold      = hold_sum[HoldW] ? HoldMax : hold_sum[HoldW-1:0];
      new_entry.repeating = wait_hit || cur_entry.repeating;
    end else begin
      new_entry.hold      = '0;
      new_entry.repeating = 1'b0;
    end

    ready = new_entry.repeating ? (new_entry.hold >= repeat_period_q)
                                : (new_entry.hold >= init_delay_q);
  end

  // Output register, loaded whenever the update stage moves on.
  logic fire_q;
  logic ready_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fire_q  <= s1_in_range_q && (s1_edge_q || ready);
      ready_q <= s1_in_range_q && ready;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fire_o         = fire_q;
  assign repeat_ready_o = ready_q;

`ifndef ASSERT_OFF
  // A beat leaving the update stage always lands in the output register.
  a_adv_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("update stage advanced without a result being held");

  // A held update stage keeps its beat and its address.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("update stage lost a stalled beat");

  // An out-of-range channel gives a quiet result.
  a_range_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_in_range_q) |=> (!fire_q && !ready_q))
    else $error("out-of-range channel produced a result bit");

  // A ready timer always fires.
  a_ready_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ready_q) |-> fire_q)
    else $error("repeat ready without fire");
`endif

endmodule

// File: rtl/iar_ram.sv
// ---------------------------------------------------------------------------
// iar_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. The read data holds while no read is requested.
// ---------------------------------------------------------------------------
module iar_ram #(
  parameter int unsigned Width = 25,
  parameter int unsigned Depth = 104
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
